[src/assert_macros.svh]
// Assertion helpers; the enclosing scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define HC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define HC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/hc_pkg.sv]
package hc_pkg;

    localparam int ALPHA      = 26;
    localparam int COF_BIAS   = 650;   // 25 * 26, keeps a cofactor non-negative
    localparam int RECIP26    = 2520;  // floor(2^16 / 26), low side
    localparam int KEY_SETTLE = 7;     // key derivation depth in cycles

    typedef logic [4:0]             letter_t;
    typedef logic [9:0]             prod_t;
    typedef logic [10:0]            acc_t;
    typedef logic [2:0][2:0][4:0]   mat_t;

    typedef enum logic [1:0] {
        REG_BLOCK_SIZE = 2'd0,
        REG_KEY_ROW0   = 2'd1,
        REG_KEY_ROW1   = 2'd2,
        REG_KEY_ROW2   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        mat_t fwd;
        mat_t inv;
        logic singular;
    } keyset_t;

    function automatic letter_t red26(input letter_t x);
        letter_t r;
        r = (x >= 5'(ALPHA)) ? x - 5'(ALPHA) : x;
        return r;
    endfunction

    function automatic letter_t neg26(input letter_t x);
        letter_t r;
        r = (x == '0) ? '0 : 5'(ALPHA) - x;
        return r;
    endfunction

    function automatic prod_t mul5(input letter_t a, input letter_t b);
        prod_t r;
        r = 10'(a) * 10'(b);
        return r;
    endfunction

    // Reciprocal estimate is q or q-1, so one correction suffices.
    function automatic letter_t mod26(input acc_t x);
        logic [22:0] prod;
        logic [6:0]  q;
        acc_t        r;
        prod = 23'(x) * 23'(RECIP26);
        q    = prod[22:16];
        r    = x - 11'(11'(q) * 11'(ALPHA));
        if (r >= 11'(ALPHA))
        begin
            r = r - 11'(ALPHA);
        end
        return r[4:0];
    endfunction

    function automatic letter_t inv26(input letter_t d);
        letter_t r;
        case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

[src/hc_if.sv]
interface hc_in_if ();
    import hc_pkg::*;

    logic    valid;
    logic    ready;
    logic    req_type;
    letter_t letter_first;
    letter_t letter_second;
    letter_t letter_third;

    modport source (
        output valid, req_type, letter_first, letter_second, letter_third,
        input  ready
    );
    modport sink (
        input  valid, req_type, letter_first, letter_second, letter_third,
        output ready
    );
endinterface

interface hc_out_if ();
    import hc_pkg::*;

    logic    valid;
    logic    ready;
    letter_t out_first;
    letter_t out_second;
    letter_t out_third;
    logic    key_not_invertible;

    modport source (
        output valid, out_first, out_second, out_third, key_not_invertible,
        input  ready
    );
    modport sink (
        input  valid, out_first, out_second, out_third, key_not_invertible,
        output ready
    );
endinterface

[src/hc_keygen.sv]
module hc_keygen (
    input  logic              clk,
    input  logic              size3,
    input  logic [2:0][14:0]  key_rows,
    output hc_pkg::keyset_t   keys
);
    import hc_pkg::*;

    mat_t                 k_next, k_reg;
    logic                 sz3_reg;
    logic [2:0][2:0][10:0] cof_next, cof_reg;
    mat_t                 cofm_next, cofm_reg;
    acc_t                 detsum_next, detsum_reg;
    letter_t              det;
    letter_t              di_next, di_reg;
    mat_t                 adj_next, adj_reg;
    logic [2:0][2:0][9:0] prodi_next, prodi_reg;
    logic                 sing_next, sing_reg;
    mat_t                 inv_next, inv_reg;

    // K1: entries reduced
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                k_next[i][j] = red26(key_rows[i][5*j +: 5]);
            end
        end
    end

    // K2: biased signed cofactors
    always_comb
    begin
        int i1, i2, j1, j2;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                i1 = (i == 2) ? 0 : i + 1;
                i2 = (i == 0) ? 2 : i - 1;
                j1 = (j == 2) ? 0 : j + 1;
                j2 = (j == 0) ? 2 : j - 1;
                cof_next[i][j] = 11'(mul5(k_reg[i1][j1], k_reg[i2][j2])) + 11'(COF_BIAS)
                               - 11'(mul5(k_reg[i1][j2], k_reg[i2][j1]));
            end
        end
    end

    // K3: cofactors mod 26
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cofm_next[i][j] = mod26(cof_reg[i][j]);
            end
        end
    end

    // K4: expansion along row 0
    assign detsum_next = 11'(mul5(k_reg[0][0], cofm_reg[0][0]))
                       + 11'(mul5(k_reg[0][1], cofm_reg[0][1]))
                       + 11'(mul5(k_reg[0][2], cofm_reg[0][2]));

    // K5: determinant inverse and adjugate
    assign det     = sz3_reg ? mod26(detsum_reg) : cofm_reg[2][2];
    assign di_next = inv26(det);

    always_comb
    begin
        adj_next = '0;
        if (sz3_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    adj_next[j][i] = cofm_reg[i][j];
                end
            end
        end
        else
        begin
            adj_next[0][0] = k_reg[1][1];
            adj_next[0][1] = neg26(k_reg[0][1]);
            adj_next[1][0] = neg26(k_reg[1][0]);
            adj_next[1][1] = k_reg[0][0];
        end
    end

    // K6: scale by inverse determinant
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prodi_next[i][j] = mul5(adj_reg[i][j], di_reg);
            end
        end
    end
    assign sing_next = (di_reg == '0);

    // K7: reduce
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                inv_next[i][j] = mod26(11'(prodi_reg[i][j]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        sz3_reg    <= size3;
        cof_reg    <= cof_next;
        cofm_reg   <= cofm_next;
        detsum_reg <= detsum_next;
        di_reg     <= di_next;
        adj_reg    <= adj_next;
        prodi_reg  <= prodi_next;
        sing_reg   <= sing_next;
        inv_reg    <= inv_next;
    end

    assign keys.fwd      = k_reg;
    assign keys.inv      = inv_reg;
    assign keys.singular = sing_reg;

endmodule

[src/hc_pipe.sv]
`include "assert_macros.svh"

module hc_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              size3,
    input  logic              settled,
    input  hc_pkg::keyset_t   keys,
    hc_in_if.sink             in_ch,
    hc_out_if.source          out_ch
);
    import hc_pkg::*;

    logic rdy1, rdy2, rdy3, rdy4, take;

    // S1: letters
    logic                  s1_valid_reg;
    logic [2:0][4:0]       s1_v_next, s1_v_reg;
    logic                  s1_dec_reg, s1_sz2_reg;
    // S2: products
    logic                  s2_valid_reg;
    mat_t                  mat;
    logic [2:0][2:0][9:0]  s2_p_next, s2_p_reg;
    logic                  s2_bad_reg, s2_sz2_reg;
    // S3: column sums
    logic                  s3_valid_reg;
    logic [2:0][10:0]      s3_sum_next, s3_sum_reg;
    logic                  s3_bad_reg, s3_sz2_reg;
    // S4: output
    logic                  out_valid_reg;
    logic [2:0][4:0]       out_l_next, out_l_reg;
    logic                  out_bad_reg;

    assign rdy4 = !out_valid_reg || out_ch.ready;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;

    assign in_ch.ready = rdy1 && settled;
    assign take        = in_ch.valid && in_ch.ready;

    assign s1_v_next[0] = red26(in_ch.letter_first);
    assign s1_v_next[1] = red26(in_ch.letter_second);
    assign s1_v_next[2] = size3 ? red26(in_ch.letter_third) : '0;

    assign mat = s1_dec_reg ? keys.inv : keys.fwd;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s2_p_next[i][j] = mul5(s1_v_reg[i], mat[i][j]);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            s3_sum_next[j] = 11'(s2_p_reg[0][j]) + 11'(s2_p_reg[1][j])
                           + 11'(s2_p_reg[2][j]);
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            out_l_next[j] = s3_bad_reg ? '0 : mod26(s3_sum_reg[j]);
        end
        if (s3_sz2_reg)
        begin
            out_l_next[2] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= take;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_v_reg   <= s1_v_next;
            s1_dec_reg <= in_ch.req_type;
            s1_sz2_reg <= !size3;
        end
        if (rdy2)
        begin
            s2_p_reg   <= s2_p_next;
            s2_bad_reg <= s1_dec_reg && keys.singular;
            s2_sz2_reg <= s1_sz2_reg;
        end
        if (rdy3)
        begin
            s3_sum_reg <= s3_sum_next;
            s3_bad_reg <= s2_bad_reg;
            s3_sz2_reg <= s2_sz2_reg;
        end
        if (rdy4)
        begin
            out_l_reg   <= out_l_next;
            out_bad_reg <= s3_bad_reg;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.out_first          = out_l_reg[0];
    assign out_ch.out_second         = out_l_reg[1];
    assign out_ch.out_third          = out_l_reg[2];
    assign out_ch.key_not_invertible = out_bad_reg;

    `HC_ASSERT(a_bad_gives_zero, out_ch.valid && out_ch.key_not_invertible |-> out_ch.out_first == 5'd0 && out_ch.out_second == 5'd0 && out_ch.out_third == 5'd0, "singular key result not zero")
    `HC_ASSERT(a_letter_range, out_ch.valid |-> out_ch.out_first < 5'd26 && out_ch.out_second < 5'd26 && out_ch.out_third < 5'd26, "result letter out of range")
    `HC_ASSERT(a_s3_advances, s3_valid_reg && rdy4 |=> out_ch.valid, "stage 3 transfer lost")
    `HC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_ch.valid, "output valid in reset")

endmodule

[src/hill_cipher_mod26.sv]
// Hill cipher mod 26, 2x2 or 3x3 key.
// in_ch carries one block per transfer: req_type (0 encrypt, 1 decrypt)
// and three letters 0..31, each reduced mod 26. out_ch carries the result
// letters and key_not_invertible, one result per input, in input order.
// The APB port holds block_size and key rows 0..2 at byte addresses 0, 4,
// 8 and 12; pready is tied high and reads return the register contents.
// An input passes registered stages (reduce, multiply, column sum, mod 26)
// to out_ch. Throughput: one block per cycle while out_ch takes results
// and no key refill is under way. The key inverse comes from a 7-stage
// derivation pipeline fed by the key registers. in_ch.ready stays low
// after reset and after every register write while that pipeline refills.
// Reset loads block_size 3 and the identity key and empties the pipeline.
// When out_ch stalls, the result holds in the output register and each
// stage still takes data while the stage ahead has room, so up to four
// blocks are held before in_ch.ready drops.
// Write registers only while no result is outstanding.
`include "assert_macros.svh"

module hill_cipher_mod26 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    hc_in_if.sink         in_ch,
    hc_out_if.source      out_ch
);
    import hc_pkg::*;

    logic [1:0]       block_size_reg;
    logic [2:0][14:0] key_rows_reg;
    logic [2:0]       settle_reg;
    logic             cfg_wr;
    logic             settled;
    logic             size3;
    reg_idx_t         idx;
    keyset_t          keys;

    assign pready  = 1'b1;
    assign idx     = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign settled = (settle_reg == '0);
    assign size3   = (block_size_reg != 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg  <= 2'd3;
            key_rows_reg[0] <= 15'd1;
            key_rows_reg[1] <= 15'd32;
            key_rows_reg[2] <= 15'd1024;
            settle_reg      <= 3'(KEY_SETTLE);
        end
        else
        begin
            if (cfg_wr)
            begin
                settle_reg <= 3'(KEY_SETTLE);
                case (idx)
                    REG_BLOCK_SIZE: block_size_reg  <= pwdata[1:0];
                    REG_KEY_ROW0:   key_rows_reg[0] <= pwdata[14:0];
                    REG_KEY_ROW1:   key_rows_reg[1] <= pwdata[14:0];
                    REG_KEY_ROW2:   key_rows_reg[2] <= pwdata[14:0];
                    default:        block_size_reg  <= block_size_reg;
                endcase
            end
            else if (!settled)
            begin
                settle_reg <= settle_reg - 3'd1;
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_BLOCK_SIZE: prdata = {30'd0, block_size_reg};
            REG_KEY_ROW0:   prdata = {17'd0, key_rows_reg[0]};
            REG_KEY_ROW1:   prdata = {17'd0, key_rows_reg[1]};
            REG_KEY_ROW2:   prdata = {17'd0, key_rows_reg[2]};
            default:        prdata = '0;
        endcase
    end

    hc_keygen u_keygen (
        .clk      (clk),
        .size3    (size3),
        .key_rows (key_rows_reg),
        .keys     (keys)
    );

    hc_pipe u_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .size3   (size3),
        .settled (settled),
        .keys    (keys),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    `HC_ASSERT(a_wr_blocks_input, cfg_wr |=> !in_ch.ready, "input open during key refill")
    `HC_ASSERT(a_settle_counts_down, !cfg_wr && !settled |=> settle_reg == $past(settle_reg) - 3'd1, "settle count skipped")

endmodule

[test/hill_cipher_mod26_test.sv]
`timescale 1ns / 1ps

module hill_cipher_mod26_test;
    import hc_pkg::*;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PERIODIC,
        SINK_HEAVY
    } sink_mode_t;

    typedef struct packed {
        letter_t first;
        letter_t second;
        letter_t third;
        logic    singular;
    } cipher_out_t;

    typedef struct packed {
        logic        cfg;
        reg_idx_t    idx;
        logic [14:0] val;
        logic        op;
        letter_t     a;
        letter_t     b;
        letter_t     c;
        logic        typed;
        cipher_out_t want;
    } plan_row_t;

    localparam cipher_out_t NONE = '0;

    // config rows use idx/val; block rows use op/letters, typed rows carry the answer
    localparam plan_row_t PLAN [38] = '{
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b1, '{5'd0, 5'd0, 5'd0, 1'b0}},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd25, 5'd25, 5'd25, 1'b1,
          '{5'd25, 5'd25, 5'd25, 1'b0}},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_DECRYPT, 5'd25, 5'd0, 5'd13, 1'b1,
          '{5'd25, 5'd0, 5'd13, 1'b0}},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd31, 5'd26, 5'd30, 1'b1,
          '{5'd5, 5'd0, 5'd4, 1'b0}},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_DECRYPT, 5'd26, 5'd27, 5'd31, 1'b1,
          '{5'd0, 5'd1, 5'd5, 1'b0}},
        '{1'b1, REG_BLOCK_SIZE, 15'd2, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd3, 5'd4, 5'd25, 1'b1,
          '{5'd3, 5'd4, 5'd0, 1'b0}},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_DECRYPT, 5'd31, 5'd0, 5'd17, 1'b1,
          '{5'd5, 5'd0, 5'd0, 1'b0}},
        '{1'b1, REG_KEY_ROW0, 15'd130, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b1, REG_KEY_ROW1, 15'd97, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_DECRYPT, 5'd7, 5'd8, 5'd9, 1'b1,
          '{5'd0, 5'd0, 5'd0, 1'b1}},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd1, 5'd0, 5'd5, 1'b1,
          '{5'd2, 5'd4, 5'd0, 1'b0}},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd10, 5'd20, 5'd3, 1'b0, NONE},
        '{1'b1, REG_KEY_ROW0, 15'd99, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b1, REG_KEY_ROW1, 15'd162, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_DECRYPT, 5'd7, 5'd8, 5'd19, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd25, 5'd31, 5'd0, 1'b0, NONE},
        '{1'b1, REG_KEY_ROW0, 15'd13, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b1, REG_KEY_ROW1, 15'd32, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_DECRYPT, 5'd1, 5'd2, 5'd3, 1'b1,
          '{5'd0, 5'd0, 5'd0, 1'b1}},
        '{1'b1, REG_KEY_ROW0, 15'd1798, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b1, REG_KEY_ROW1, 15'd10765, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b1, REG_KEY_ROW2, 15'd15924, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b1, REG_BLOCK_SIZE, 15'd3, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd0, 5'd2, 5'd19, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_DECRYPT, 5'd15, 5'd14, 5'd7, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_DECRYPT, 5'd25, 5'd25, 5'd25, 1'b0, NONE},
        '{1'b1, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd1, 5'd0, 5'd0, 1'b1,
          '{5'd6, 5'd24, 5'd1, 1'b0}},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_DECRYPT, 5'd3, 5'd1, 5'd4, 1'b0, NONE},
        '{1'b1, REG_BLOCK_SIZE, 15'd1, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd0, 5'd0, 5'd1, 1'b1,
          '{5'd20, 5'd17, 5'd15, 1'b0}},
        '{1'b1, REG_KEY_ROW2, 15'd28511, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd0, 5'd0, 5'd1, 1'b1,
          '{5'd5, 5'd0, 5'd1, 1'b0}},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_DECRYPT, 5'd9, 5'd9, 5'd9, 1'b0, NONE},
        '{1'b1, REG_KEY_ROW2, 15'd0, OP_ENCRYPT, 5'd0, 5'd0, 5'd0, 1'b0, NONE},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_DECRYPT, 5'd25, 5'd25, 5'd25, 1'b1,
          '{5'd0, 5'd0, 5'd0, 1'b1}},
        '{1'b0, REG_BLOCK_SIZE, 15'd0, OP_ENCRYPT, 5'd0, 5'd1, 5'd0, 1'b1,
          '{5'd13, 5'd16, 5'd10, 1'b0}}
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hc_in_if  in_ch ();
    hc_out_if out_ch ();

    hill_cipher_mod26 uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    logic [1:0]  size_reg;
    logic [14:0] key_reg [3];
    cipher_out_t pending_q [$];
    int          failures = 0;
    int          stall_tick = 0;
    sink_mode_t  sink_mode;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int mod26_of(input int x);
        int r;
        r = x % 26;
        return (r < 0) ? r + 26 : r;
    endfunction

    function automatic int recip_mod26(input int d);
        int x;
        for (x = 1; x < 26; x++)
        begin
            if ((d * x) % 26 == 1)
            begin
                return x;
            end
        end
        return 0;
    endfunction

    function automatic cipher_out_t hill_predict(input logic op, input letter_t a,
                                                 input letter_t b, input letter_t c);
        int          k [3][3];
        int          m [3][3];
        int          v [3];
        int          res [3];
        int          n;
        int          det;
        int          di;
        int          cof;
        int          acc;
        int          i;
        int          j;
        logic        singular;
        cipher_out_t r;
        n = (size_reg == 2'd2) ? 2 : 3;
        for (i = 0; i < 3; i++)
        begin
            for (j = 0; j < 3; j++)
            begin
                k[i][j] = mod26_of(int'(key_reg[i][5 * j +: 5]));
                m[i][j] = 0;
            end
            res[i] = 0;
        end
        v[0] = mod26_of(int'(a));
        v[1] = mod26_of(int'(b));
        v[2] = (n == 3) ? mod26_of(int'(c)) : 0;
        singular = 1'b0;
        if (op == OP_ENCRYPT)
        begin
            m = k;
        end
        else
        begin
            if (n == 2)
            begin
                det = mod26_of(k[0][0] * k[1][1] - k[0][1] * k[1][0]);
            end
            else
            begin
                det = mod26_of(k[0][0] * (k[1][1] * k[2][2] - k[1][2] * k[2][1])
                             - k[0][1] * (k[1][0] * k[2][2] - k[1][2] * k[2][0])
                             + k[0][2] * (k[1][0] * k[2][1] - k[1][1] * k[2][0]));
            end
            di = recip_mod26(det);
            if (di == 0)
            begin
                singular = 1'b1;
            end
            else if (n == 2)
            begin
                m[0][0] = mod26_of(k[1][1] * di);
                m[0][1] = mod26_of(-k[0][1] * di);
                m[1][0] = mod26_of(-k[1][0] * di);
                m[1][1] = mod26_of(k[0][0] * di);
            end
            else
            begin
                // inverse = adjugate * det^-1, adjugate is the cofactor transpose
                for (i = 0; i < 3; i++)
                begin
                    for (j = 0; j < 3; j++)
                    begin
                        cof = k[(i + 1) % 3][(j + 1) % 3] * k[(i + 2) % 3][(j + 2) % 3]
                            - k[(i + 1) % 3][(j + 2) % 3] * k[(i + 2) % 3][(j + 1) % 3];
                        m[j][i] = mod26_of(mod26_of(cof) * di);
                    end
                end
            end
        end
        if (!singular)
        begin
            for (j = 0; j < n; j++)
            begin
                acc = 0;
                for (i = 0; i < n; i++)
                begin
                    acc += v[i] * m[i][j];
                end
                res[j] = mod26_of(acc);
            end
        end
        r.first    = letter_t'(res[0]);
        r.second   = letter_t'(res[1]);
        r.third    = (n == 3) ? letter_t'(res[2]) : letter_t'(0);
        r.singular = singular;
        return r;
    endfunction

    function automatic letter_t rand_letter();
        if ($urandom_range(0, 15) == 0)
        begin
            return letter_t'($urandom_range(26, 31));
        end
        return letter_t'($urandom_range(0, 25));
    endfunction

    function automatic logic [14:0] rand_row();
        int top;
        top = ($urandom_range(0, 3) == 0) ? 31 : 25;
        return {5'($urandom_range(0, top)), 5'($urandom_range(0, top)),
                5'($urandom_range(0, top))};
    endfunction

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [14:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {17'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BLOCK_SIZE)
        begin
            size_reg = val[1:0];
        end
        else
        begin
            key_reg[int'(idx) - 1] = val;
        end
    endtask

    task automatic load_key(input logic [1:0] bsize, input logic [14:0] r0,
                            input logic [14:0] r1, input logic [14:0] r2);
        drain();
        reg_write(REG_KEY_ROW0, r0);
        reg_write(REG_KEY_ROW1, r1);
        reg_write(REG_KEY_ROW2, r2);
        reg_write(REG_BLOCK_SIZE, 15'(bsize));
    endtask

    task automatic send_block(input logic op, input letter_t a, input letter_t b,
                              input letter_t c, input logic typed, input cipher_out_t want);
        @(negedge clk);
        in_ch.valid         <= 1'b1;
        in_ch.req_type      <= op;
        in_ch.letter_first  <= a;
        in_ch.letter_second <= b;
        in_ch.letter_third  <= c;
        do
        begin
            @(posedge clk);
        end
        while (in_ch.ready !== 1'b1);
        pending_q.push_back(typed ? want : hill_predict(op, a, b, c));
    endtask

    task automatic hold_off(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic run_phase(input int count, input int max_gap, input bit pause_mid);
        int burst;
        int i;
        burst = 0;
        for (i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
            begin
                drain();
            end
            if (burst == 0)
            begin
                burst = $urandom_range(1, 16);
                hold_off((max_gap == 0) ? 0 : $urandom_range(0, max_gap));
            end
            send_block(1'($urandom_range(0, 1)), rand_letter(), rand_letter(), rand_letter(),
                       1'b0, NONE);
            burst--;
        end
    endtask

    always @(negedge clk)
    begin
        stall_tick++;
        case (sink_mode)
            SINK_OPEN:     out_ch.ready <= 1'b1;
            SINK_RANDOM:   out_ch.ready <= ($urandom_range(0, 2) != 0);
            SINK_PERIODIC: out_ch.ready <= ((stall_tick % 7) < 4);
            default:       out_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cipher_out_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result transfer with no block outstanding");
                failures++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (out_ch.out_first !== want.first)
                begin
                    $error("out_first: expected %0d, got %0d", want.first, out_ch.out_first);
                    failures++;
                end
                if (out_ch.out_second !== want.second)
                begin
                    $error("out_second: expected %0d, got %0d", want.second,
                           out_ch.out_second);
                    failures++;
                end
                if (out_ch.out_third !== want.third)
                begin
                    $error("out_third: expected %0d, got %0d", want.third, out_ch.out_third);
                    failures++;
                end
                if (out_ch.key_not_invertible !== want.singular)
                begin
                    $error("key_not_invertible: expected %0d, got %0d", want.singular,
                           out_ch.key_not_invertible);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int p;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_ch.valid         = 1'b0;
        in_ch.req_type      = OP_ENCRYPT;
        in_ch.letter_first  = '0;
        in_ch.letter_second = '0;
        in_ch.letter_third  = '0;
        out_ch.ready        = 1'b0;
        sink_mode           = SINK_RANDOM;
        size_reg            = 2'd3;
        key_reg             = '{15'd1, 15'd32, 15'd1024};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (PLAN[i])
        begin
            if (PLAN[i].cfg)
            begin
                drain();
                reg_write(PLAN[i].idx, PLAN[i].val);
            end
            else
            begin
                send_block(PLAN[i].op, PLAN[i].a, PLAN[i].b, PLAN[i].c, PLAN[i].typed,
                           PLAN[i].want);
            end
        end

        // extreme keys: all entries 31, all zero, all 25
        sink_mode = SINK_OPEN;
        load_key(2'd3, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        run_phase(40, 0, 1'b0);
        sink_mode = SINK_HEAVY;
        load_key(2'd2, 15'd0, 15'd0, 15'd0);
        run_phase(40, 3, 1'b0);
        sink_mode = SINK_PERIODIC;
        load_key(2'd0, 15'd26425, 15'd26425, 15'd26425);
        run_phase(40, 2, 1'b0);

        for (p = 0; p < 13; p++)
        begin
            sink_mode = sink_mode_t'(p % 4);
            load_key(($urandom_range(0, 2) == 0) ? 2'd2 : 2'($urandom_range(0, 3)),
                     rand_row(), rand_row(), rand_row());
            run_phase(125, (p % 3 == 0) ? 0 : $urandom_range(1, 8), (p % 5 == 2));
        end

        drain();
        repeat (10) @(posedge clk);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
